>>> rtl/cwnd_pkg.sv
// ----------------------------------------------------------------------------
// cwnd_pkg
// Shared types and constants for the congestion window unit.
// ----------------------------------------------------------------------------
package cwnd_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int PKT_W   = 7;
  localparam int THR_W   = 7;
  localparam int DUP_W   = 3;
  localparam int LIMIT_W = 3;
  localparam int FUNC_W  = 2;
  localparam int PHASE_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [PKT_W-1:0]   MAX_WINDOW_RST = 7'd20;
  localparam logic [THR_W-1:0]   INIT_THR_RST   = 7'd16;
  localparam logic [LIMIT_W-1:0] DUP_LIMIT_RST  = 3'd3;
  localparam logic [THR_W-1:0]   RECOVERY_BUMP  = 7'd3;

  localparam logic [FUNC_W-1:0] FUNC_NEW_ACK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DUP_ACK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  localparam logic [PHASE_W-1:0] PH_SLOW_START = 2'd0;
  localparam logic [PHASE_W-1:0] PH_AVOID      = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RECOVERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_LIMIT    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_ADD,
    S_CMP,
    S_CLAMP,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic [PKT_W-1:0]   max_window;
    logic [LIMIT_W-1:0] dup_limit;
  } cwnd_cfg_t;

endpackage

>>> rtl/cwnd_alu.sv
// ----------------------------------------------------------------------------
// cwnd_alu
// Shared add / subtract unit with carry out (carry set on subtract means a >= b).
// ----------------------------------------------------------------------------
module cwnd_alu #(
  parameter int W = 18
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         co
);

  logic [W-1:0] b_op;

  always_comb begin
    b_op = sub ? ~b : b;
    {co, res} = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};
  end

endmodule

>>> rtl/cwnd_core.sv
// ----------------------------------------------------------------------------
// cwnd_core
// Event sequencer and window state; all wide arithmetic goes through one ALU.
// ----------------------------------------------------------------------------
module cwnd_core
  import cwnd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int WIN_W = PKT_W + FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cwnd_cfg_t            cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic                 in_all_acked,
  input  logic                 out_stall,
  output logic                 done,
  output logic [WIN_W-1:0]     window,
  output logic [THR_W-1:0]     threshold,
  output logic [PHASE_W-1:0]   phase
);

  localparam int QW    = 2 * FRACTION_BITS + 1;
  localparam int ALU_W = ((WIN_W > QW) ? WIN_W : QW) + 1;
  localparam int CNT_W = $clog2(QW);
  localparam logic [ALU_W-1:0] ONE_W = {{(ALU_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic [QW-1:0]    ONE_Q = {{(QW-1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  seq_state_t          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic                acked_r, acked_nxt;
  logic [WIN_W-1:0]    window_r, window_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [DUP_W-1:0]    dup_r, dup_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [ALU_W-1:0]    work_r, work_nxt;
  logic [QW-1:0]       inc_r, inc_nxt;
  logic [WIN_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [ALU_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_sub, alu_co;

  logic [THR_W-1:0]    half_pkts;
  logic [THR_W-1:0]    recov_pkts;
  logic [DUP_W-1:0]    dup_inc;
  logic [ALU_W-1:0]    thr_fx;
  logic [ALU_W-1:0]    limit_fx;

  cwnd_alu #(.W(ALU_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .co  (alu_co)
  );

  assign half_pkts  = {1'b0, window_r[WIN_W-1:FRACTION_BITS+1]};
  assign recov_pkts = half_pkts + RECOVERY_BUMP;
  assign dup_inc    = (dup_r == {DUP_W{1'b1}}) ? dup_r : dup_r + 1'b1;
  assign thr_fx     = ALU_W'({thr_r, {FRACTION_BITS{1'b0}}});
  assign limit_fx   = ALU_W'({cfg.max_window, {FRACTION_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      window_r <= WIN_W'(ONE_W);
      thr_r    <= INIT_THR_RST;
      dup_r    <= '0;
      phase_r  <= PH_SLOW_START;
    end else begin
      state_r  <= state_nxt;
      window_r <= window_nxt;
      thr_r    <= thr_nxt;
      dup_r    <= dup_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    acked_r <= acked_nxt;
    work_r  <= work_nxt;
    inc_r   <= inc_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    acked_nxt  = acked_r;
    window_nxt = window_r;
    thr_nxt    = thr_r;
    dup_nxt    = dup_r;
    phase_nxt  = phase_r;
    work_nxt   = work_r;
    inc_nxt    = inc_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    alu_a      = work_r;
    alu_b      = ALU_W'(inc_r);
    alu_sub    = 1'b0;
    in_ready   = 1'b0;
    done       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt  = in_func;
          acked_nxt = in_all_acked;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        work_nxt = ALU_W'(window_r);
        inc_nxt  = ONE_Q;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        case (func_r)
          FUNC_NEW_ACK: begin
            dup_nxt = '0;
            case (phase_r)
              PH_SLOW_START: state_nxt = S_ADD;
              PH_AVOID: begin
                state_nxt = (window_r == '0) ? S_ADD : S_DIV;
              end
              default: begin
                if (acked_r) begin
                  work_nxt  = thr_fx;
                  phase_nxt = PH_AVOID;
                  state_nxt = S_CLAMP;
                end else begin
                  state_nxt = S_ADD;
                end
              end
            endcase
          end
          FUNC_DUP_ACK: begin
            if (phase_r == PH_RECOVERY) begin
              state_nxt = S_ADD;
            end else begin
              dup_nxt   = dup_inc;
              state_nxt = S_CLAMP;
              if (dup_inc == cfg.dup_limit) begin
                thr_nxt   = half_pkts;
                work_nxt  = ALU_W'({recov_pkts, {FRACTION_BITS{1'b0}}});
                phase_nxt = PH_RECOVERY;
              end
            end
          end
          FUNC_TIMEOUT: begin
            thr_nxt   = half_pkts;
            work_nxt  = ONE_W;
            dup_nxt   = '0;
            phase_nxt = PH_SLOW_START;
            state_nxt = S_CLAMP;
          end
          default: state_nxt = S_OUT;
        endcase
      end

      // restoring divide of ONE*ONE by the window, one quotient bit a cycle
      S_DIV: begin
        alu_a   = ALU_W'({rem_r, (cnt_r == '0)});
        alu_b   = ALU_W'(window_r);
        alu_sub = 1'b1;
        rem_nxt = alu_co ? alu_res[WIN_W-1:0] : alu_a[WIN_W-1:0];
        inc_nxt = {inc_r[QW-2:0], alu_co};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        work_nxt = alu_res;
        if (func_r == FUNC_NEW_ACK && phase_r == PH_SLOW_START) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_CLAMP;
        end
      end

      S_CMP: begin
        alu_b   = thr_fx;
        alu_sub = 1'b1;
        if (alu_co) begin
          phase_nxt = PH_AVOID;
        end
        state_nxt = S_CLAMP;
      end

      S_CLAMP: begin
        alu_a      = limit_fx;
        alu_b      = work_r;
        alu_sub    = 1'b1;
        window_nxt = alu_co ? work_r[WIN_W-1:0] : limit_fx[WIN_W-1:0];
        state_nxt  = S_OUT;
      end

      S_OUT: begin
        if (!out_stall) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign window    = window_r;
  assign threshold = thr_r;
  assign phase     = phase_r;

endmodule

>>> rtl/tcp_reno_congestion_window_unit.sv
// ----------------------------------------------------------------------------
// tcp_reno_congestion_window_unit
// NewReno congestion window controller: one result per ACK / timeout event.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_func, in_all_acked
//   out      output     out_valid / out_ready window_fixed/whole, threshold, phase
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// The avoidance increment is set by the bit-serial divider, one quotient bit
// a cycle through the shared ALU. Input is taken only while the sequencer is
// idle. A result waits in the output register; the sequencer holds its last
// step while that is full and out_ready is low. Reset is synchronous; the
// threshold resets to 16 and a write of the initial threshold register has
// no later effect.
// ----------------------------------------------------------------------------
module tcp_reno_congestion_window_unit
  import cwnd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [FUNC_W-1:0]                in_func,
  input  logic                             in_all_acked,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [PKT_W+FRACTION_BITS-1:0]   out_window_fixed,
  output logic [PKT_W-1:0]                 out_window_whole,
  output logic [THR_W-1:0]                 out_threshold,
  output logic [PHASE_W-1:0]               out_phase
);

  localparam int WIN_W = PKT_W + FRACTION_BITS;

  cwnd_cfg_t           cfg_r, cfg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]    win_out_r;
  logic [THR_W-1:0]    thr_out_r;
  logic [PHASE_W-1:0]  phase_out_r;

  logic                done;
  logic                out_stall;
  logic [WIN_W-1:0]    core_window;
  logic [THR_W-1:0]    core_thr;
  logic [PHASE_W-1:0]  core_phase;

  assign out_stall = out_valid_r & ~out_ready;

  cwnd_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_all_acked (in_all_acked),
    .out_stall    (out_stall),
    .done         (done),
    .window       (core_window),
    .threshold    (core_thr),
    .phase        (core_phase)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_WINDOW:  cfg_nxt.max_window = cfg_wdata[PKT_W-1:0];
        CFG_INIT_THRESH: cfg_nxt = cfg_r;  // only the reset value is used
        CFG_DUP_LIMIT:   cfg_nxt.dup_limit  = cfg_wdata[LIMIT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_window <= MAX_WINDOW_RST;
      cfg_r.dup_limit  <= DUP_LIMIT_RST;
      out_valid_r      <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      win_out_r   <= core_window;
      thr_out_r   <= core_thr;
      phase_out_r <= core_phase;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_fixed = win_out_r;
  assign out_window_whole = win_out_r[WIN_W-1:FRACTION_BITS];
  assign out_threshold    = thr_out_r;
  assign out_phase        = phase_out_r;

endmodule

>>> rtl/cwnd_checker.sv
// ----------------------------------------------------------------------------
// cwnd_checker
// Port-level checks for the congestion window unit, bound to the top level.
// ----------------------------------------------------------------------------
module cwnd_checker
  import cwnd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [PKT_W+FRACTION_BITS-1:0] out_window_fixed,
  input logic [PKT_W-1:0]               out_window_whole,
  input logic [PHASE_W-1:0]             out_phase
);

  a_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an event is in progress");

  a_whole_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_whole == out_window_fixed[PKT_W+FRACTION_BITS-1:FRACTION_BITS]))
    else $error("whole window disagrees with fixed point window");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase == PH_SLOW_START || out_phase == PH_AVOID ||
                   out_phase == PH_RECOVERY))
    else $error("unknown phase on result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_window_fixed)))
    else $error("stalled result dropped or changed");

endmodule

bind tcp_reno_congestion_window_unit cwnd_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_cwnd_checker (.*);
